/* rtl/mwo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwo_pkg
// shared types, register indexes, waveform codes and constants of the
// multi-waveform oscillator
// ----------------------------------------------------------------------------
package mwo_pkg;

  // defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int PHASE_BITS_DEF  = 32;

  // fixed by the field widths
  localparam int SAMPLE_BITS   = 16;
  localparam int SINE_POINTS   = 1024;
  localparam int SINE_IDX_BITS = $clog2(SINE_POINTS);
  localparam logic [31:0] SINE_MASK = ~((32'd1 << (32 - SINE_IDX_BITS)) - 32'd1);

  // sin(pi/2 x) = x(A - x^2(B - C x^2)), Q2.30
  localparam logic [31:0] SIN_A = 32'd1686629713;
  localparam logic [31:0] SIN_B = 32'd688904866;
  localparam logic [31:0] SIN_C = 32'd76016977;

  localparam logic signed [16:0] W_POS = 17'sd32768;
  localparam logic signed [16:0] W_NEG = -17'sd32768;

  // command queue depth
  localparam int QUEUE_DEPTH = 4;

  // opcodes of an input word
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // waveform codes
  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_SAW    = 3'd2;
  localparam logic [2:0] WAVE_TRI    = 3'd3;
  localparam logic [2:0] WAVE_TABLE  = 3'd4;

  // register indexes
  localparam logic [2:0] CFG_WAVE_SELECT  = 3'd0;
  localparam logic [2:0] CFG_PHASE_STEP   = 3'd1;
  localparam logic [2:0] CFG_PHASE_OFFSET = 3'd2;
  localparam logic [2:0] CFG_DUTY         = 3'd3;
  localparam logic [2:0] CFG_AMPLITUDE    = 3'd4;
  localparam logic [2:0] CFG_TABLE_LEN    = 3'd5;
  localparam logic [2:0] CFG_OCTAVE_SHIFT = 3'd6;

  typedef struct packed {
    logic              opcode;
    logic [7:0]        entry_index;
    logic signed [15:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               cycle_wrap;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  wave_select;
    logic [31:0] phase_step;
    logic [31:0] phase_offset;
    logic [15:0] duty;
    logic [15:0] amplitude;
    logic [3:0]  table_len_log2;
    logic [2:0]  table_octave_shift;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               op;
    logic               wrap;
    logic [31:0]        phase;
    logic signed [15:0] value;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/multi_waveform_oscillator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// phase-accumulator oscillator: sine, square, saw, triangle and wavetable
// ----------------------------------------------------------------------------
// path: a tick word runs through the command queue, five pipeline stages
//   and the output register before its result word is valid
// throughput: one word per cycle (single-issue) unless out_ready stalls it
// reset: synchronous active-low rst_n clears accumulators, queue, stage
//   valids and loads register defaults; the wavetable is not cleared
// ----------------------------------------------------------------------------
module multi_waveform_oscillator
  import mwo_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration write port
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  // input words
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_word,
  // result words
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_word
);

  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int Q_W    = TBL_AW + $bits(cmd_t);

  // configuration registers
  cfg_t cfg_r, cfg_nxt;

  // front to queue
  logic              push_valid, push_ready;
  cmd_t              push_cmd;
  logic [TBL_AW-1:0] push_addr;

  // queue to back
  logic              q_valid, q_ready;
  logic [Q_W-1:0]    q_data;
  cmd_t              q_cmd;
  logic [TBL_AW-1:0] q_addr;

  // register write decode; unknown indexes fall through untouched
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WAVE_SELECT:  cfg_nxt.wave_select        = cfg_data[2:0];
        CFG_PHASE_STEP:   cfg_nxt.phase_step         = cfg_data;
        CFG_PHASE_OFFSET: cfg_nxt.phase_offset       = cfg_data;
        CFG_DUTY:         cfg_nxt.duty               = cfg_data[15:0];
        CFG_AMPLITUDE:    cfg_nxt.amplitude          = cfg_data[15:0];
        CFG_TABLE_LEN:    cfg_nxt.table_len_log2     = cfg_data[3:0];
        CFG_OCTAVE_SHIFT: cfg_nxt.table_octave_shift = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_select        <= WAVE_SINE;
      cfg_r.phase_step         <= '0;
      cfg_r.phase_offset       <= '0;
      cfg_r.duty               <= 16'd32768;
      cfg_r.amplitude          <= 16'd32768;
      cfg_r.table_len_log2     <= 4'd5;
      cfg_r.table_octave_shift <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accepts words, steps the accumulators, builds commands;
  // out-of-range table writes are consumed here and never queued
  mwo_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PHASE_BITS  (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .push_addr  (push_addr)
  );

  // queue decouples the front from output back-pressure
  mwo_fifo #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_addr, push_cmd}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_addr = q_data[Q_W-1 -: TBL_AW];
  assign q_cmd  = q_data[$bits(cmd_t)-1:0];

  // back: table memory, waveform pipeline, scaling, output register
  mwo_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .q_addr    (q_addr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

/* rtl/mwo_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwo_front
// accepts input words, advances the phase accumulators and forms commands
// ----------------------------------------------------------------------------
module mwo_front
  import mwo_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  localparam int TBL_AW     = $clog2(TABLE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_word_t          in_word,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output cmd_t                   push_cmd,
  output logic [TBL_AW-1:0]      push_addr
);

  localparam int K_MAX = $clog2(TABLE_DEPTH + 1) - 1;

  logic [PHASE_BITS-1:0]    phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0]    table_acc_r, table_acc_nxt;
  logic [PHASE_BITS+31:0]   phase_ext, table_ext;
  logic [31:0]              phase_now, table_now;
  logic [PHASE_BITS:0]      phase_sum;
  logic [3:0]               k_eff;
  logic [TBL_AW+31:0]       tidx_wide;
  logic                     is_tick, wr_in_range, take;

  always_comb begin
    // top 32 bits of each accumulator, left-aligned when narrower
    phase_ext = {phase_acc_r, 32'b0};
    table_ext = {table_acc_r, 32'b0};
    phase_now = phase_ext[PHASE_BITS+31 -: 32] + cfg.phase_offset;
    table_now = table_ext[PHASE_BITS+31 -: 32] + cfg.phase_offset;

    k_eff = (cfg.table_len_log2 < 4'(K_MAX)) ? cfg.table_len_log2 : 4'(K_MAX);
    tidx_wide = {{TBL_AW{1'b0}}, table_now} << k_eff;

    is_tick     = (in_word.opcode == OP_TICK);
    wr_in_range = ({24'b0, in_word.entry_index} < 32'(TABLE_DEPTH));

    in_ready   = push_ready;
    push_valid = in_valid && (is_tick || wr_in_range);
    take       = in_valid && in_ready && is_tick;

    phase_sum = {1'b0, phase_acc_r} + {1'b0, PHASE_BITS'(cfg.phase_step)};

    push_cmd.op    = in_word.opcode;
    push_cmd.wrap  = phase_sum[PHASE_BITS];
    push_cmd.phase = phase_now;
    push_cmd.value = in_word.entry_value;
    push_addr      = is_tick ? tidx_wide[TBL_AW+31:32] : TBL_AW'(in_word.entry_index);

    phase_acc_nxt = phase_acc_r;
    table_acc_nxt = table_acc_r;
    if (take) begin
      phase_acc_nxt = phase_sum[PHASE_BITS-1:0];
      table_acc_nxt = table_acc_r
                    + PHASE_BITS'(cfg.phase_step >> cfg.table_octave_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      table_acc_r <= '0;
    end else begin
      phase_acc_r <= phase_acc_nxt;
      table_acc_r <= table_acc_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/mwo_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwo_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module mwo_fifo
  import mwo_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output logic [DATA_W-1:0]      rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_wr, do_rd;

  always_comb begin
    wr_ready = (count_r != CNT_W'(QUEUE_DEPTH));
    rd_valid = (count_r != '0);
    rd_data  = slot_r[rd_ptr_r];
    do_wr    = wr_valid && wr_ready;
    do_rd    = rd_valid && rd_ready;
    wr_ptr_nxt = do_wr ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/mwo_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwo_back
// wavetable memory, waveform pipeline, amplitude scaling and output register
// ----------------------------------------------------------------------------
module mwo_back
  import mwo_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int TBL_AW     = $clog2(TABLE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire cmd_t              q_cmd,
  input  wire logic [TBL_AW-1:0] q_addr,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_word_t              out_word
);

  localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (SAMPLE_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] SAT_LO = -(34'sd1 <<< (SAMPLE_BITS - 1));

  logic signed [15:0] table_mem_r [TABLE_DEPTH];
  logic signed [15:0] rd_data_r;

  logic advance;

  // stage registers
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, out_valid_r;
  logic s1_wrap_r, s2_wrap_r, s3_wrap_r, s4_wrap_r, s5_wrap_r;
  logic s1_neg_r, s2_neg_r, s3_neg_r, s4_neg_r;
  logic signed [16:0] s1_w_r, s2_w_r, s3_w_r, s4_w_r, s5_w_r;
  logic [30:0] s1_x_r, s2_x_r, s3_x_r, s4_x_r;
  logic [30:0] s2_x2_r, s3_x2_r;
  logic [29:0] s3_tb_r;
  logic [30:0] s4_ta_r;
  out_word_t   out_word_r;

  // combinational
  logic [31:0]        q_sine;
  logic [30:0]        x_s1;
  logic [32:0]        tri_abs;
  logic [17:0]        tri_val;
  logic signed [16:0] w_s1;
  logic [61:0]        m2, m3, m4, m5;
  logic [29:0]        tb_s3;
  logic [30:0]        ta_s4;
  logic [32:0]        rnd_s5;
  logic signed [16:0] mag_s5, w_s5;
  logic signed [33:0] prod_s6, shr_s6;
  logic signed [33:0] sat_s6;

  assign advance   = !out_valid_r || out_ready;
  assign q_ready   = advance;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // stage 1: quadrant fold for the sine, direct waveforms
  always_comb begin
    q_sine = q_cmd.phase & SINE_MASK;
    x_s1   = q_sine[30] ? (31'h4000_0000 - {1'b0, q_sine[29:0]}) : {1'b0, q_sine[29:0]};
    tri_abs = q_cmd.phase[31] ? (33'h1_0000_0000 - {1'b0, q_cmd.phase})
                              : {1'b0, q_cmd.phase};
    tri_val = tri_abs[32:15] - 18'd32768;
    case (cfg.wave_select)
      WAVE_SQUARE: w_s1 = (q_cmd.phase[31:16] < cfg.duty) ? W_POS : W_NEG;
      WAVE_SAW:    w_s1 = {q_cmd.phase[31], q_cmd.phase[31:16]};
      WAVE_TRI:    w_s1 = tri_val[16:0];
      default:     w_s1 = '0;
    endcase
  end

  // sine polynomial, one multiply per stage
  always_comb begin
    m2 = 62'(s1_x_r) * 62'(s1_x_r);
    m3 = 62'(SIN_C) * 62'(s2_x2_r);
    tb_s3 = SIN_B[29:0] - m3[59:30];
    m4 = 62'(s3_tb_r) * 62'(s3_x2_r);
    ta_s4 = SIN_A[30:0] - m4[60:30];
    m5 = 62'(s4_ta_r) * 62'(s4_x_r);
    rnd_s5 = {1'b0, m5[61:30]} + 33'd16384;
    mag_s5 = $signed(rnd_s5[31:15]);
    // user must change config only while idle (unchecked) so select is stable
    if (cfg.wave_select == WAVE_SINE) begin
      w_s5 = s4_neg_r ? -mag_s5 : mag_s5;
    end else begin
      w_s5 = s4_w_r;
    end
  end

  // amplitude scaling with rounding and saturation
  always_comb begin
    prod_s6 = 34'(s5_w_r) * 34'($signed({1'b0, cfg.amplitude})) + 34'sd16384;
    shr_s6  = prod_s6 >>> 15;
    if (shr_s6 > SAT_HI) begin
      sat_s6 = SAT_HI;
    end else if (shr_s6 < SAT_LO) begin
      sat_s6 = SAT_LO;
    end else begin
      sat_s6 = shr_s6;
    end
  end

  // wavetable memory, write and registered read in stage 1
  always_ff @(posedge clk) begin
    if (advance && q_valid && (q_cmd.op == OP_WRITE)) begin
      table_mem_r[q_addr] <= q_cmd.value;
    end
    if (advance) begin
      rd_data_r <= table_mem_r[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= q_valid && (q_cmd.op == OP_TICK);
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_wrap_r <= q_cmd.wrap;
      s1_neg_r  <= q_sine[31];
      s1_w_r    <= w_s1;
      s1_x_r    <= x_s1;

      s2_wrap_r <= s1_wrap_r;
      s2_neg_r  <= s1_neg_r;
      s2_w_r    <= (cfg.wave_select == WAVE_TABLE) ? 17'(rd_data_r) : s1_w_r;
      s2_x_r    <= s1_x_r;
      s2_x2_r   <= m2[60:30];

      s3_wrap_r <= s2_wrap_r;
      s3_neg_r  <= s2_neg_r;
      s3_w_r    <= s2_w_r;
      s3_x_r    <= s2_x_r;
      s3_x2_r   <= s2_x2_r;
      s3_tb_r   <= tb_s3;

      s4_wrap_r <= s3_wrap_r;
      s4_neg_r  <= s3_neg_r;
      s4_w_r    <= s3_w_r;
      s4_x_r    <= s3_x_r;
      s4_ta_r   <= ta_s4;

      s5_wrap_r <= s4_wrap_r;
      s5_w_r    <= w_s5;

      out_word_r.sample     <= sat_s6[SAMPLE_BITS-1:0];
      out_word_r.cycle_wrap <= s5_wrap_r;
    end
  end

endmodule
`default_nettype wire

/* sim/multi_waveform_oscillator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_tb
// Self-checking bench for the multi-waveform oscillator. The wavetable is
// loaded in full first. A short directed table then walks every waveform,
// the field extremes and the odd register settings. After that come random
// segments, each one started from a quiet block with fresh register values.
// Every tick word is run through a local oscillator model and compared field
// by field with the result words. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator_tb;
  import mwo_pkg::*;

  localparam int HALF_NS        = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 10;     // tail wait past the pipeline, with margin
  localparam int RANDOM_WORDS   = 1600;
  localparam int TIMEOUT_NS     = 2_000_000;
  localparam int MAX_REPORTS    = 10;
  localparam int TABLE_ENTRIES  = 256;
  localparam int TABLE_LOG2_MAX = 8;      // largest k with 2^k <= table depth

  // codes the package leaves out
  localparam logic [2:0] CFG_NONE      = 3'd7;  // no register behind this index
  localparam logic [2:0] WAVE_SPARE_LO = 3'd5;  // unused waveform codes
  localparam logic [2:0] WAVE_SPARE_HI = 3'd7;

  // kinds of directed row
  localparam logic ROW_REG  = 1'b1;
  localparam logic ROW_WORD = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    in_word_t    word;
    logic        pinned;   // expected word typed in below, not predicted
    out_word_t   want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_word;

  // side band that travels with the word on the input channel
  logic        pinned;
  out_word_t   pinned_word;

  // idle rates, in percent
  int src_gap_pct;
  int sink_stall_pct;

  // oscillator model state
  cfg_t               shadow;
  logic [31:0]        phase_acc;
  logic [31:0]        table_acc;
  logic signed [15:0] wavetable_mirror [TABLE_ENTRIES];

  out_word_t expected_samples [$];
  plan_row_t plan [$];
  int        fault_count;

  multi_waveform_oscillator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #HALF_NS;
    clk = 1'b1;
    #HALF_NS;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("multi_waveform_oscillator regression: fail");
    $finish;
  end

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // oscillator model
  // ---------------------------------------------------------------------------

  // quarter-wave polynomial sine at 1024 points, all products cut by 30 bits
  function automatic int sine_value(logic [31:0] p);
    logic [1:0]  quad;
    logic [63:0] x, x2, t, y, mag;
    int          m;
    quad = p[31:30];
    // point index back to an angle drops the low 22 phase bits
    x = {34'd0, p[29:22], 22'd0};
    if (quad[0]) begin
      x = (64'd1 << 30) - x;
    end
    x2  = (x * x) >> 30;
    t   = (x2 * SIN_C) >> 30;
    t   = SIN_B - t;
    t   = (t * x2) >> 30;
    t   = SIN_A - t;
    y   = (t * x) >> 30;
    mag = (y + 64'd16384) >> 15;   // round half up to q1.15
    m   = mag[31:0];
    return quad[1] ? -m : m;
  endfunction

  // result of one tick; advances both accumulators afterwards
  function automatic out_word_t next_sample();
    logic [31:0] p, tp, sh;
    logic [32:0] sum;
    logic [17:0] a;
    logic [3:0]  k;
    int          w;
    longint      acc, amp;
    out_word_t   r;
    p = phase_acc + shadow.phase_offset;
    case (shadow.wave_select)
      WAVE_SINE:   w = sine_value(p);
      WAVE_SQUARE: w = (p[31:16] < shadow.duty) ? 32768 : -32768;
      WAVE_SAW:    w = {{16{p[31]}}, p[31:16]};
      WAVE_TRI: begin
        // fold around half a cycle, peak of +32768 at the midpoint
        sum = p[31] ? (33'h1_0000_0000 - {1'b0, p}) : {1'b0, p};
        a   = sum[32:15];
        w   = int'(a);
        w   = w - 32768;
      end
      WAVE_TABLE: begin
        // nearest entry, addressed by the top k bits of the table phase
        k  = (shadow.table_len_log2 > TABLE_LOG2_MAX) ? TABLE_LOG2_MAX :
             shadow.table_len_log2;
        tp = table_acc + shadow.phase_offset;
        sh = tp >> (32 - k);
        w  = int'(wavetable_mirror[sh[7:0]]);
      end
      default:     w = 0;
    endcase
    // q15 gain with round half up, then clamp to 16 bits
    amp = longint'(shadow.amplitude);
    acc = longint'(w);
    acc = (acc * amp + 64'sd16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    if (acc < -32768) begin
      acc = -32768;
    end
    sum          = {1'b0, phase_acc} + {1'b0, shadow.phase_step};
    phase_acc    = sum[31:0];
    table_acc    = table_acc + (shadow.phase_step >> shadow.table_octave_shift);
    r.sample     = acc[15:0];
    r.cycle_wrap = sum[32];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: push on each accepted tick, pop on each accepted result
  // ---------------------------------------------------------------------------
  task automatic log_fault(string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    out_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_word.opcode == OP_WRITE) begin
          wavetable_mirror[in_word.entry_index] = in_word.entry_value;
        end else begin
          // model always runs so its state stays in step with the block
          want = next_sample();
          if (pinned) begin
            want = pinned_word;
          end
          expected_samples.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          log_fault($sformatf("unexpected word: sample %0d wrap %0b at %0t",
                              out_word.sample, out_word.cycle_wrap, $realtime));
        end else begin
          want = expected_samples.pop_front();
          if (want.sample !== out_word.sample ||
              want.cycle_wrap !== out_word.cycle_wrap) begin
            log_fault($sformatf(
              "mismatch at %0t: sample want %0d got %0d, wrap want %0b got %0b",
              $realtime, want.sample, out_word.sample, want.cycle_wrap,
              out_word.cycle_wrap));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one word, with a random gap ahead of it; returns on the accept edge
  task automatic send_word(in_word_t w, logic pin, out_word_t want);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_word     <= w;
    pinned      <= pin;
    pinned_word <= want;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // hold the sender off until every result is back and the pipe is empty;
  // table writes give no result, so the tail wait covers them
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever issued on a quiet block
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_WAVE_SELECT:  shadow.wave_select        = val[2:0];
      CFG_PHASE_STEP:   shadow.phase_step         = val;
      CFG_PHASE_OFFSET: shadow.phase_offset       = val;
      CFG_DUTY:         shadow.duty               = val[15:0];
      CFG_AMPLITUDE:    shadow.amplitude          = val[15:0];
      CFG_TABLE_LEN:    shadow.table_len_log2     = val[3:0];
      CFG_OCTAVE_SHIFT: shadow.table_octave_shift = val[2:0];
      default: ;        // no register here, the block ignores it
    endcase
  endtask

  // phase-like value, biased toward the corners and small steps
  function automatic logic [31:0] corner32();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // fresh register set for a random segment
  task automatic shuffle_settings();
    logic [31:0] v;
    if ($urandom_range(0, 9) == 0) begin
      write_reg(CFG_WAVE_SELECT, $urandom_range(WAVE_SPARE_LO, WAVE_SPARE_HI));
    end else begin
      write_reg(CFG_WAVE_SELECT, $urandom_range(WAVE_SINE, WAVE_TABLE));
    end
    if ($urandom_range(0, 2) != 0) begin
      write_reg(CFG_PHASE_STEP, corner32());
    end
    if ($urandom_range(0, 2) != 0) begin
      write_reg(CFG_PHASE_OFFSET, corner32());
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 3))
        0:       v = 32'h0000;
        1:       v = 32'hFFFF;
        2:       v = 32'h8000;
        default: v = $urandom_range(0, 16'hFFFF);
      endcase
      write_reg(CFG_DUTY, v);
    end
    if ($urandom_range(0, 2) != 0) begin
      // gain above full scale is legal and must saturate
      case ($urandom_range(0, 4))
        0:       v = 32'h0000;
        1:       v = 32'h8000;
        2:       v = 32'hFFFF;
        3:       v = $urandom_range(0, 16'h8000);
        default: v = $urandom_range(0, 16'hFFFF);
      endcase
      write_reg(CFG_AMPLITUDE, v);
    end
    if ($urandom_range(0, 2) != 0) begin
      write_reg(CFG_TABLE_LEN, $urandom_range(0, 15));
    end
    if ($urandom_range(0, 2) != 0) begin
      write_reg(CFG_OCTAVE_SHIFT, $urandom_range(0, 7));
    end
    if ($urandom_range(0, 7) == 0) begin
      write_reg(CFG_NONE, $urandom);
    end
  endtask

  // directed row builders
  function automatic plan_row_t reg_row(logic [2:0] idx, logic [31:0] val);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // tick with don't-care table fields; pin = 1 uses the typed result
  function automatic plan_row_t tick_row(logic pin, logic [15:0] s, logic wrap);
    plan_row_t r;
    r                  = '0;
    r.kind             = ROW_WORD;
    r.word.opcode      = OP_TICK;
    r.word.entry_index = 8'($urandom);
    r.word.entry_value = 16'($urandom);
    r.pinned           = pin;
    r.want.sample      = s;
    r.want.cycle_wrap  = wrap;
    return r;
  endfunction

  function automatic plan_row_t load_row(logic [7:0] idx, logic [15:0] val);
    plan_row_t r;
    r                  = '0;
    r.kind             = ROW_WORD;
    r.word.opcode      = OP_WRITE;
    r.word.entry_index = idx;
    r.word.entry_value = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_word_t w;
    int       done;
    int       seg;

    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_WAVE_SELECT;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_word        = '0;
    pinned         = 1'b0;
    pinned_word    = '0;
    src_gap_pct    = 33;
    sink_stall_pct = 62;
    fault_count    = 0;

    // register defaults and cleared accumulators
    shadow.wave_select        = WAVE_SINE;
    shadow.phase_step         = 32'd0;
    shadow.phase_offset       = 32'd0;
    shadow.duty               = 16'h8000;
    shadow.amplitude          = 16'h8000;
    shadow.table_len_log2     = 4'd5;
    shadow.table_octave_shift = 3'd0;
    phase_acc                 = 32'd0;
    table_acc                 = 32'd0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // load every wavetable entry so no read ever hits an unwritten one
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      w.opcode      = OP_WRITE;
      w.entry_index = i[7:0];
      w.entry_value = 16'($urandom);
      send_word(w, 1'b0, '0);
    end

    // directed table; step stays zero until the sine rows, so the phase
    // is just the offset and the pinned results follow from it
    plan.push_back(tick_row(1'b1, 16'sh0000, 1'b0));        // sine at zero phase
    plan.push_back(reg_row(CFG_WAVE_SELECT, WAVE_SQUARE));
    plan.push_back(tick_row(1'b1, 16'sh7FFF, 1'b0));        // high half, clipped
    plan.push_back(reg_row(CFG_PHASE_OFFSET, 32'h8000_0000));
    plan.push_back(tick_row(1'b1, 16'sh8000, 1'b0));        // exactly at duty
    plan.push_back(reg_row(CFG_DUTY, 32'hFFFF));
    plan.push_back(tick_row(1'b1, 16'sh7FFF, 1'b0));
    plan.push_back(reg_row(CFG_DUTY, 32'h0000));
    plan.push_back(tick_row(1'b1, 16'sh8000, 1'b0));        // zero duty never high
    plan.push_back(reg_row(CFG_WAVE_SELECT, WAVE_SAW));
    plan.push_back(reg_row(CFG_PHASE_OFFSET, 32'h7FFF_FFFF));
    plan.push_back(tick_row(1'b1, 16'sh7FFF, 1'b0));        // saw top
    plan.push_back(reg_row(CFG_PHASE_OFFSET, 32'h8000_0000));
    plan.push_back(tick_row(1'b1, 16'sh8000, 1'b0));        // saw bottom
    plan.push_back(reg_row(CFG_WAVE_SELECT, WAVE_TRI));
    plan.push_back(tick_row(1'b1, 16'sh7FFF, 1'b0));        // triangle peak clipped
    plan.push_back(reg_row(CFG_PHASE_OFFSET, 32'h0000_0000));
    plan.push_back(tick_row(1'b1, 16'sh8000, 1'b0));        // triangle trough
    plan.push_back(reg_row(CFG_AMPLITUDE, 32'h0000));
    plan.push_back(tick_row(1'b1, 16'sh0000, 1'b0));        // muted
    plan.push_back(reg_row(CFG_AMPLITUDE, 32'hFFFF));       // gain near two
    plan.push_back(reg_row(CFG_PHASE_OFFSET, 32'h6000_0000));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));
    plan.push_back(reg_row(CFG_WAVE_SELECT, WAVE_SPARE_LO));
    plan.push_back(tick_row(1'b1, 16'sh0000, 1'b0));        // unused waveform
    plan.push_back(reg_row(CFG_WAVE_SELECT, WAVE_SPARE_HI));
    plan.push_back(reg_row(CFG_NONE, 32'hFFFF_FFFF));       // must change nothing
    plan.push_back(tick_row(1'b1, 16'sh0000, 1'b0));
    plan.push_back(reg_row(CFG_WAVE_SELECT, WAVE_SINE));
    plan.push_back(reg_row(CFG_AMPLITUDE, 32'h8000));
    plan.push_back(reg_row(CFG_PHASE_OFFSET, 32'h4000_0000));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));        // sine crest
    plan.push_back(reg_row(CFG_PHASE_OFFSET, 32'hC000_0000));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));        // sine trough
    plan.push_back(reg_row(CFG_PHASE_STEP, 32'hFFFF_FFFF));
    plan.push_back(reg_row(CFG_PHASE_OFFSET, 32'h0000_0000));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));        // first wrap
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));
    plan.push_back(reg_row(CFG_WAVE_SELECT, WAVE_TABLE));
    plan.push_back(reg_row(CFG_TABLE_LEN, 32'd0));          // always entry zero
    plan.push_back(reg_row(CFG_OCTAVE_SHIFT, 32'd7));
    plan.push_back(load_row(8'h00, 16'h7FFF));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));
    plan.push_back(reg_row(CFG_TABLE_LEN, 32'd15));         // clamps to full table
    plan.push_back(load_row(8'hFF, 16'h8000));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));
    plan.push_back(reg_row(CFG_TABLE_LEN, 32'd8));
    plan.push_back(reg_row(CFG_OCTAVE_SHIFT, 32'd0));
    plan.push_back(reg_row(CFG_PHASE_OFFSET, 32'hFFFF_FFFF));
    plan.push_back(load_row(8'h55, 16'h5555));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));
    plan.push_back(tick_row(1'b0, 16'sh0000, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].word, plan[i].pinned, plan[i].want);
      end
    end

    // random segments: settle, new registers, then a burst of words;
    // idle pattern by thirds, last third runs flat out
    done = 0;
    while (done < RANDOM_WORDS) begin
      case (done * 3 / RANDOM_WORDS)
        0: begin
          src_gap_pct    = 33;
          sink_stall_pct = 62;
        end
        1: begin
          src_gap_pct    = 62;
          sink_stall_pct = 33;
        end
        default: begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
      endcase
      settle();
      shuffle_settings();
      seg = $urandom_range(8, 60);
      repeat (seg) begin
        // mostly ticks; table fields carry noise on ticks as well
        w.opcode      = ($urandom_range(0, 99) < 12) ? OP_WRITE : OP_TICK;
        w.entry_index = 8'($urandom);
        w.entry_value = 16'($urandom);
        send_word(w, 1'b0, '0);
        done++;
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("multi_waveform_oscillator regression: pass");
    end else begin
      $display("multi_waveform_oscillator regression: fail");
    end
    $finish;
  end

endmodule
